// ----- hdl/lad_pkg.sv -----
`default_nettype none

package lad_pkg;

   // Request kinds carried in req_tuser
   typedef enum logic [1:0] {
      KIND_PUSH_REAR  = 2'd0,
      KIND_PUSH_FRONT = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_REAR   = 2'd3
   } kind_type;

   // Response status codes carried in rsp_tuser
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_FULL_REAR  = 2'd1;
   localparam logic [1:0] STATUS_FULL_FRONT = 2'd2;
   localparam logic [1:0] STATUS_EMPTY      = 2'd3;

   // Field widths
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CAP_W   = 5;
   localparam int unsigned RSP_W   = 104;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   // Sequencer states
   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_LOOKUP = 1'b1
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/linear_array_deque.sv -----
`default_nettype none

// Double-ended queue kept in a linear (non-circular) slot memory of DEPTH
// entries. Push-rear appends after the last element and fails with status
// "full at rear" once the rear index reaches capacity minus one; push-front
// only reuses slots freed by earlier front pops and fails with "full at front"
// otherwise; pops on an empty queue return status "empty". Each request gives
// exactly one response with the popped element and the first and last
// elements left in the queue. The first and last elements are cached in
// registers, so a request needs at most one registered read of the slot
// memory. No request is taken before the last response is posted, but one
// is taken while that response is being accepted. The user must write the
// capacity register (reset 16, clamped to 1..DEPTH) via csr_wr_en / csr_wr_data
// only while no request is in flight; the block does not enforce this. Slots
// hold DATA_WIDTH bits and are sign-extended to 32 bits on the way out.
module linear_array_deque #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [lad_pkg::VALUE_W-1:0]      req_tdata,  // [31:0] value
   input  wire logic [lad_pkg::KIND_W-1:0]       req_tuser,  // [1:0] kind
   // response channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [31:0] popped, [32] is_empty, [64:33] front_value, [96:65] rear_value,
   // [103:97] zero
   output logic [lad_pkg::RSP_W-1:0]             rsp_tdata,
   output logic [1:0]                            rsp_tuser,  // [1:0] status
   // capacity register
   input  wire logic                             csr_wr_en,
   input  wire logic [lad_pkg::CAP_W-1:0]        csr_wr_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned IW = AW + 1;

   // Convert between the 32-bit request field and a stored slot
   function automatic logic [DATA_WIDTH-1:0] to_slot(input logic [31:0] v);
      logic signed [63:0] e;
      e = 64'(signed'(v));
      return e[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] from_slot(input logic [DATA_WIDTH-1:0] d);
      logic signed [63:0] e;
      e = 64'(signed'(d));
      return e[31:0];
   endfunction

   // Control and payload registers
   lad_pkg::state_type          state_ff, state_in;
   logic signed [IW-1:0]        head_ff, head_in;
   logic signed [IW-1:0]        tail_ff, tail_in;
   logic [DATA_WIDTH-1:0]       front_ff, front_in;
   logic [DATA_WIDTH-1:0]       rear_ff, rear_in;
   logic                        load_front_ff, load_front_in;
   logic                        load_rear_ff, load_rear_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  status_ff, status_in;
   logic [31:0]                 popped_ff, popped_in;
   logic [lad_pkg::CAP_W-1:0]   capacity_ff;

   // Slot memory
   logic [DATA_WIDTH-1:0]       slots_mem [DEPTH];
   logic [DATA_WIDTH-1:0]       mem_rdata_ff;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [DATA_WIDTH-1:0]       mem_wdata;
   logic                        mem_re;
   logic [AW-1:0]               mem_raddr;

   logic                        req_fire;
   logic                        was_empty;
   logic signed [IW-1:0]        cap_last;
   logic signed [IW-1:0]        head_up;
   logic signed [IW-1:0]        head_up2;
   logic signed [IW-1:0]        tail_up;
   logic signed [IW-1:0]        tail_dn;
   lad_pkg::kind_type           kind;

   assign req_tready = (state_ff == lad_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign kind       = lad_pkg::kind_type'(req_tuser);
   assign was_empty  = (head_ff == tail_ff);
   assign head_up    = head_ff + IW'(1);
   assign head_up2   = head_ff + IW'(2);
   assign tail_up    = tail_ff + IW'(1);
   assign tail_dn    = tail_ff - IW'(1);

   // Last usable slot index from the clamped capacity
   always_comb begin
      if (capacity_ff == '0) begin
         cap_last = '0;
      end else if (32'(capacity_ff) > 32'(DEPTH)) begin
         cap_last = IW'(DEPTH - 1);
      end else begin
         cap_last = IW'(32'(capacity_ff) - 32'd1);
      end
   end

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      load_front_in = load_front_ff;
      load_rear_in  = load_rear_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      status_in     = status_ff;
      popped_in     = popped_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = to_slot(req_tdata);
      mem_re        = 1'b0;
      mem_raddr     = '0;

      unique case (state_ff)
         lad_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in      = lad_pkg::ST_LOOKUP;
               load_front_in = 1'b0;
               load_rear_in  = 1'b0;
               status_in     = lad_pkg::STATUS_OK;
               popped_in     = '0;
               unique case (kind)
                  lad_pkg::KIND_PUSH_REAR: begin
                     if (tail_ff >= cap_last) begin
                        status_in = lad_pkg::STATUS_FULL_REAR;
                     end else begin
                        tail_in   = tail_up;
                        mem_we    = 1'b1;
                        mem_waddr = tail_up[AW-1:0];
                        rear_in   = to_slot(req_tdata);
                        if (was_empty) begin
                           front_in = to_slot(req_tdata);
                        end
                     end
                  end
                  lad_pkg::KIND_PUSH_FRONT: begin
                     if (head_ff < 0) begin
                        status_in = lad_pkg::STATUS_FULL_FRONT;
                     end else begin
                        head_in   = head_ff - IW'(1);
                        mem_we    = 1'b1;
                        mem_waddr = head_ff[AW-1:0];
                        front_in  = to_slot(req_tdata);
                        if (was_empty) begin
                           rear_in = to_slot(req_tdata);
                        end
                     end
                  end
                  lad_pkg::KIND_POP_FRONT: begin
                     if (was_empty) begin
                        status_in = lad_pkg::STATUS_EMPTY;
                     end else begin
                        head_in   = head_up;
                        popped_in = from_slot(front_ff);
                        // fetch the new first element unless the queue drains
                        if (head_up != tail_ff) begin
                           mem_re        = 1'b1;
                           mem_raddr     = head_up2[AW-1:0];
                           load_front_in = 1'b1;
                        end
                     end
                  end
                  lad_pkg::KIND_POP_REAR: begin
                     if (was_empty) begin
                        status_in = lad_pkg::STATUS_EMPTY;
                     end else begin
                        tail_in   = tail_dn;
                        popped_in = from_slot(rear_ff);
                        // fetch the new last element unless the queue drains
                        if (head_ff != tail_dn) begin
                           mem_re       = 1'b1;
                           mem_raddr    = tail_dn[AW-1:0];
                           load_rear_in = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         lad_pkg::ST_LOOKUP: begin
            // take the fetched element into the cache and post the response
            if (load_front_ff) begin
               front_in = mem_rdata_ff;
            end
            if (load_rear_ff) begin
               rear_in = mem_rdata_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = lad_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lad_pkg::ST_IDLE;
         head_ff       <= '1;
         tail_ff       <= '1;
         load_front_ff <= 1'b0;
         load_rear_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         capacity_ff   <= lad_pkg::CAPACITY_RESET;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         load_front_ff <= load_front_in;
         load_rear_ff  <= load_rear_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      front_ff  <= front_in;
      rear_ff   <= rear_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   // Slot memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= slots_mem[mem_raddr];
      end
   end

   // Drive the response channel
   logic [31:0] front_out;
   logic [31:0] rear_out;

   assign front_out  = was_empty ? 32'd0 : from_slot(front_ff);
   assign rear_out   = was_empty ? 32'd0 : from_slot(rear_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {7'd0, rear_out, front_out, was_empty, popped_ff};

`ifndef SYNTHESIS
   a_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("head index passed tail index");

   a_lookup: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == lad_pkg::ST_LOOKUP) && !rsp_valid_ff)
      else $error("accepted request did not enter lookup");

   a_post: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lad_pkg::ST_LOOKUP) |=> rsp_valid_ff)
      else $error("lookup did not post a response");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == lad_pkg::STATUS_EMPTY) |-> was_empty)
      else $error("empty status on a non-empty queue");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      !(load_front_ff && load_rear_ff))
      else $error("both cached ends scheduled for reload");
`endif

endmodule

`default_nettype wire
